// ----- rtl/wmd_pkg.sv -----
`default_nettype none
package wmd_pkg;
   localparam int MaxWidth   = 1024;
   localparam int MaxHeight  = 1024;
   localparam int MaxRadius  = 8;
   localparam int KernelSide = 2 * MaxRadius + 1;
   localparam int KernelSize = KernelSide * KernelSide;
   localparam int LsRows     = 2 * MaxRadius + 2;
   localparam int LsDepth    = LsRows * MaxWidth;
   localparam int ColW  = $clog2(MaxWidth);
   localparam int RowW  = $clog2(MaxHeight);
   localparam int LsRowW = $clog2(LsRows);
   localparam int LsAddrW = $clog2(LsDepth);
   localparam int KAddrW = $clog2(KernelSize);
   localparam int KIdxW = $clog2(KernelSide);
   localparam int CsrIdxW = 2;
   localparam int CsrDataW = 11;
   localparam int RadW = 4;
   localparam int WeightW = 9;
   localparam logic [WeightW-1:0] Unity = 9'd256;

   localparam logic [1:0] CmdWeight = 2'd0;
   localparam logic [1:0] CmdPixel  = 2'd1;
   localparam logic [1:0] CmdDrain  = 2'd2;
   localparam logic [1:0] CmdSpare  = 2'd3;

   localparam logic [CsrIdxW-1:0] RegWidth  = 2'd0;
   localparam logic [CsrIdxW-1:0] RegHeight = 2'd1;
   localparam logic [CsrIdxW-1:0] RegRadius = 2'd2;

   typedef struct packed {
      logic [1:0] command;
      logic [4:0] kernel_row;
      logic [4:0] kernel_col;
      logic [8:0] kernel_weight;
      logic [7:0] source_pixel;
   } req_type;

   typedef struct packed {
      logic [7:0] out_pixel;
      logic [9:0] out_col;
      logic [9:0] out_row;
      logic       frame_last;
   } rsp_type;

   // Controller to datapath.
   typedef struct packed {
      logic clear;    // write zero to the next kernel entry
      logic load;     // capture item, update stores and counters
      logic win_init; // start window walk
      logic tap;      // issue one tap read
      logic emit;     // place result into output register
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic clear_done; // last kernel entry being cleared
      logic ready_out;  // an output is due
      logic win_done;   // last tap issued
      logic pipe_empty; // no tap reads in flight
   } sts_type;
endpackage
`default_nettype wire

// ----- rtl/wmd_stream_if.sv -----
`default_nettype none
interface wmd_stream_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ----- rtl/wmd_ram.sv -----
`default_nettype none
module wmd_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   // One write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// ----- rtl/wmd_ctrl.sv -----
`default_nettype none
module wmd_ctrl (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   output wmd_pkg::cmd_type     cmd,
   input  wire wmd_pkg::sts_type sts
);
   typedef enum logic [2:0] {
      ST_CLEAR, ST_IDLE, ST_CHECK, ST_WALK, ST_FLUSH, ST_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;

   // Commands decoded from the current state.
   always_comb begin
      cmd          = '0;
      cmd.clear    = (state_ff == ST_CLEAR);
      cmd.load     = req_valid && req_ready;
      cmd.win_init = (state_ff == ST_CHECK) && sts.ready_out;
      cmd.tap      = (state_ff == ST_WALK);
      cmd.emit     = (state_ff == ST_EMIT) && !rsp_valid_ff;
   end

   // Next state and output-valid logic.
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_CLEAR: begin
            if (sts.clear_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (cmd.load) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            state_in = sts.ready_out ? ST_WALK : ST_IDLE;
         end
         ST_WALK: begin
            if (sts.win_done) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            if (sts.pipe_empty) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end
endmodule
`default_nettype wire

// ----- rtl/wmd_datapath.sv -----
`default_nettype none
module wmd_datapath (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_write,
   input  wire logic [wmd_pkg::CsrIdxW-1:0]       csr_index,
   input  wire logic [wmd_pkg::CsrDataW-1:0]      csr_data,
   input  wire wmd_pkg::req_type                  req,
   output wmd_pkg::rsp_type                       rsp,
   input  wire wmd_pkg::cmd_type                  cmd,
   output wmd_pkg::sts_type                       sts
);
   localparam int CW = wmd_pkg::ColW;
   localparam int RW = wmd_pkg::RowW;
   localparam int KW = wmd_pkg::KIdxW;
   localparam int SW = wmd_pkg::LsRowW;

   // Configuration registers.
   logic [10:0] width_ff, height_ff;
   logic [3:0]  radius_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 11'd256;
         height_ff <= 11'd256;
         radius_ff <= 4'd2;
      end else if (csr_write) begin
         unique case (csr_index)
            wmd_pkg::RegWidth:  width_ff  <= csr_data;
            wmd_pkg::RegHeight: height_ff <= csr_data;
            wmd_pkg::RegRadius: radius_ff <= csr_data[3:0];
            default: ;
         endcase
      end
   end

   // Effective sizes, clamped.
   logic [10:0] w_eff, h_eff;
   logic [4:0]  r_eff;
   always_comb begin
      w_eff = (width_ff == 11'd0) ? 11'd1 :
              (width_ff > 11'(wmd_pkg::MaxWidth)) ? 11'(wmd_pkg::MaxWidth) : width_ff;
      h_eff = (height_ff == 11'd0) ? 11'd1 :
              (height_ff > 11'(wmd_pkg::MaxHeight)) ? 11'(wmd_pkg::MaxHeight) : height_ff;
      r_eff = (radius_ff > 4'(wmd_pkg::MaxRadius)) ? 5'(wmd_pkg::MaxRadius)
                                                   : {1'b0, radius_ff};
   end

   // Kernel store; a clearing pass after reset writes zero to every entry.
   logic                           kwr;
   logic [wmd_pkg::KAddrW-1:0]     kwr_addr, krd_addr;
   logic [wmd_pkg::WeightW-1:0]    kwr_data, krd_data;
   logic [wmd_pkg::KAddrW-1:0]     clr_addr_ff;
   logic                           kram_we;
   logic [wmd_pkg::KAddrW-1:0]     kram_waddr;
   logic [wmd_pkg::WeightW-1:0]    kram_wdata;

   assign kwr = cmd.load && (req.command == wmd_pkg::CmdWeight) &&
                (req.kernel_row < 5'(wmd_pkg::KernelSide)) &&
                (req.kernel_col < 5'(wmd_pkg::KernelSide));
   assign kwr_addr = wmd_pkg::KAddrW'(req.kernel_row * wmd_pkg::KernelSide
                                      + req.kernel_col);
   assign kwr_data = (req.kernel_weight > wmd_pkg::Unity) ? wmd_pkg::Unity
                                                          : req.kernel_weight;
   assign kram_we    = kwr || cmd.clear;
   assign kram_waddr = cmd.clear ? clr_addr_ff : kwr_addr;
   assign kram_wdata = cmd.clear ? '0 : kwr_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
      end else if (cmd.clear) begin
         clr_addr_ff <= clr_addr_ff + wmd_pkg::KAddrW'(1);
      end
   end

   wmd_ram #(.Width(wmd_pkg::WeightW), .Depth(wmd_pkg::KernelSize)) u_kram (
      .clock(clock), .wr_en(kram_we), .wr_addr(kram_waddr), .wr_data(kram_wdata),
      .rd_addr(krd_addr), .rd_data(krd_data)
   );

   // Input and emit counters.
   logic [CW-1:0]  in_col_ff, emit_col_ff;
   logic [RW-1:0]  in_row_ff, emit_row_ff;
   logic [SW-1:0]  in_slot_ff, emit_slot_ff;
   logic           done_ff;
   logic           wt_item_ff;
   logic           store_px;
   logic [wmd_pkg::LsAddrW-1:0] lrd_addr;
   logic [7:0]                  lrd_data;

   assign store_px = cmd.load && (req.command == wmd_pkg::CmdPixel) && !done_ff;

   wmd_ram #(.Width(8), .Depth(wmd_pkg::LsDepth)) u_lram (
      .clock(clock), .wr_en(store_px),
      .wr_addr({in_slot_ff, in_col_ff}), .wr_data(req.source_pixel),
      .rd_addr(lrd_addr), .rd_data(lrd_data)
   );

   // Readiness of the next output; a weight write never releases one.
   logic [11:0] rx_sum, ry_sum;
   logic [10:0] rx, ry;
   logic        ready_out_c;
   always_comb begin
      rx_sum = 12'(emit_col_ff) + 12'(r_eff);
      ry_sum = 12'(emit_row_ff) + 12'(r_eff);
      rx = (rx_sum < 12'(w_eff)) ? rx_sum[10:0] : w_eff - 11'd1;
      ry = (ry_sum < 12'(h_eff)) ? ry_sum[10:0] : h_eff - 11'd1;
      ready_out_c = !wt_item_ff && (done_ff || (11'(in_row_ff) > ry) ||
                    ((11'(in_row_ff) == ry) && (11'(in_col_ff) > rx)));
   end

   // Window walk: ky/kx count 0..2r; source q = p + r - k.
   logic [KW-1:0] ky_ff, kx_ff;
   logic [5:0]    side;
   logic signed [12:0] qy, qx;
   logic signed [6:0]  slot_raw;
   logic          in_img;
   logic [SW-1:0] qslot;
   logic          win_done_c;
   assign side = 6'({r_eff, 1'b0});
   always_comb begin
      qy = 13'(emit_row_ff) + 13'(r_eff) - 13'(ky_ff);
      qx = 13'(emit_col_ff) + 13'(r_eff) - 13'(kx_ff);
      in_img = (qy >= 0) && (qy < 13'(h_eff)) && (qx >= 0) && (qx < 13'(w_eff));
      // Line store row of the source, wrapped once in either direction.
      slot_raw = 7'(emit_slot_ff) + 7'(r_eff) - 7'(ky_ff);
      if (slot_raw < 0) begin
         qslot = SW'(slot_raw + 7'(wmd_pkg::LsRows));
      end else if (slot_raw >= 7'(wmd_pkg::LsRows)) begin
         qslot = SW'(slot_raw - 7'(wmd_pkg::LsRows));
      end else begin
         qslot = SW'(slot_raw);
      end
      lrd_addr = {qslot, qx[CW-1:0]};
      krd_addr = wmd_pkg::KAddrW'(ky_ff * wmd_pkg::KernelSide + kx_ff);
      win_done_c = (6'(ky_ff) == side) && (6'(kx_ff) == side);
   end

   always_ff @(posedge clock) begin
      if (cmd.win_init) begin
         ky_ff <= '0;
         kx_ff <= '0;
      end else if (cmd.tap) begin
         if (6'(kx_ff) == side) begin
            kx_ff <= '0;
            ky_ff <= ky_ff + KW'(1);
         end else begin
            kx_ff <= kx_ff + KW'(1);
         end
      end
   end

   // Tap pipeline: read stage, multiply stage, max accumulate.
   logic       s1_ff, s2_ff;
   logic [16:0] prod_ff;
   logic [7:0]  best_ff;
   logic [8:0]  v;
   assign v  = 9'((prod_ff + 17'd128) >> 8);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff <= 1'b0;
         s2_ff <= 1'b0;
      end else begin
         s1_ff <= cmd.tap && in_img;
         s2_ff <= s1_ff;
      end
      prod_ff <= 17'(lrd_data) * 17'(krd_data);
      if (cmd.win_init) begin
         best_ff <= '0;
      end else if (s2_ff && (v > 9'(best_ff))) begin
         best_ff <= (v > 9'd255) ? 8'd255 : v[7:0];
      end
   end

   // Status back to the controller.
   assign sts = '{clear_done: (clr_addr_ff == wmd_pkg::KAddrW'(wmd_pkg::KernelSize - 1)),
                  ready_out:  ready_out_c,
                  win_done:   win_done_c,
                  pipe_empty: !s1_ff && !s2_ff && !cmd.tap};

   // Counters and output register.
   logic last;
   assign last = (11'(emit_col_ff) + 11'd1 >= w_eff) && (11'(emit_row_ff) + 11'd1 >= h_eff);
   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff    <= '0;
         in_row_ff    <= '0;
         in_slot_ff   <= '0;
         emit_col_ff  <= '0;
         emit_row_ff  <= '0;
         emit_slot_ff <= '0;
         done_ff      <= 1'b0;
         wt_item_ff   <= 1'b0;
      end else begin
         if (cmd.load) begin
            wt_item_ff <= (req.command == wmd_pkg::CmdWeight);
         end
         if (store_px) begin
            if (11'(in_col_ff) + 11'd1 >= w_eff) begin
               in_col_ff <= '0;
               if (11'(in_row_ff) + 11'd1 >= h_eff) begin
                  in_row_ff  <= '0;
                  in_slot_ff <= '0;
                  done_ff    <= 1'b1;
               end else begin
                  in_row_ff  <= in_row_ff + RW'(1);
                  in_slot_ff <= (in_slot_ff == SW'(wmd_pkg::LsRows - 1))
                                ? '0 : in_slot_ff + SW'(1);
               end
            end else begin
               in_col_ff <= in_col_ff + CW'(1);
            end
         end
         if (cmd.emit) begin
            if (11'(emit_col_ff) + 11'd1 >= w_eff) begin
               emit_col_ff <= '0;
               if (last) begin
                  emit_row_ff  <= '0;
                  emit_slot_ff <= '0;
                  done_ff      <= 1'b0;
               end else begin
                  emit_row_ff  <= emit_row_ff + RW'(1);
                  emit_slot_ff <= (emit_slot_ff == SW'(wmd_pkg::LsRows - 1))
                                  ? '0 : emit_slot_ff + SW'(1);
               end
            end else begin
               emit_col_ff <= emit_col_ff + CW'(1);
            end
         end
      end
      if (cmd.emit) begin
         rsp.out_pixel  <= best_ff;
         rsp.out_col    <= emit_col_ff;
         rsp.out_row    <= emit_row_ff;
         rsp.frame_last <= last;
      end
   end
endmodule
`default_nettype wire

// ----- rtl/weighted_max_dilation.sv -----
// Weighted grayscale dilation for glyph outlines.
// Input channel req carries commands: a kernel weight write, a source pixel
// in raster order, or a drain tick. Each transfer releases at most one
// output pixel on rsp, in raster order, once its window is complete.
// The user must write registers image_width, image_height and radius on the
// csr port only while the block is idle; the block does not enforce this.
// A transfer that releases nothing passes through a check state and back
// to idle before the next is taken. One that releases an output walks the
// (2r+1)^2 window through a single multiply-and-max unit, one tap a cycle,
// with a three-stage tap pipeline that drains before the result is emitted.
// One item is in work at a time; the result sits in an output register and
// the next item is taken only once that register is free, so a stalled
// receiver holds the input side too.
// Reset clears counters and state; a clearing pass then writes zero to every
// kernel weight, and no transfer is taken until it has ended.
// The line store needs no clearing.
`default_nettype none
module weighted_max_dilation (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         csr_write,
   input  wire logic [wmd_pkg::CsrIdxW-1:0]  csr_index,
   input  wire logic [wmd_pkg::CsrDataW-1:0] csr_data,
   wmd_stream_if.sink                        req_if,
   wmd_stream_if.source                      rsp_if
);
   wmd_pkg::cmd_type cmd;
   wmd_pkg::sts_type sts;

   wmd_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_if.valid), .req_ready(req_if.ready),
      .rsp_valid(rsp_if.valid), .rsp_ready(rsp_if.ready),
      .cmd(cmd), .sts(sts)
   );

   wmd_datapath u_dp (
      .clock(clock), .reset(reset),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data),
      .req(req_if.payload), .rsp(rsp_if.payload),
      .cmd(cmd), .sts(sts)
   );

   // A transfer is only taken while no result waits.
   assert property (@(posedge clock) disable iff (reset)
      req_if.ready |-> !rsp_if.valid)
      else $error("input taken while a result waits");

   // The output register is never loaded while it still holds a result.
   assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> !rsp_if.valid)
      else $error("result overwritten");

   // A window walk never starts beside an accepted transfer.
   assert property (@(posedge clock) disable iff (reset)
      cmd.win_init |-> !cmd.load && !cmd.tap)
      else $error("window start overlaps other work");
endmodule
`default_nettype wire
